// ===== design/scce_pkg.sv =====
// shared types, constants and crc function for the smart config length code encoder
`default_nettype none
package scce_pkg;

  localparam int unsigned PASSWORD_MAX = 64;
  localparam int unsigned SSID_MAX     = 32;
  localparam int unsigned IpLimit      = 4;
  localparam int unsigned BssidLimit   = 6;
  localparam int unsigned HdrItems     = 5;
  localparam int unsigned QDepth       = 4;

  localparam int unsigned IpCntW  = $clog2(IpLimit + 1);
  localparam int unsigned PwCntW  = $clog2(PASSWORD_MAX + 1);
  localparam int unsigned SsCntW  = $clog2(SSID_MAX + 1);
  localparam int unsigned BsCntW  = $clog2(BssidLimit + 1);
  localparam int unsigned HdrCntW = $clog2(HdrItems);
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [7:0] CrcPoly    = 8'h8c;
  localparam logic [9:0] CodeOffset = 10'd40;
  localparam logic [7:0] IdxBase    = 8'd9;
  localparam logic [7:0] IpIdxBase  = 8'd5;

  typedef enum logic [2:0] {
    MODE_IP       = 3'd0,
    MODE_PASSWORD = 3'd1,
    MODE_SSID     = 3'd2,
    MODE_BSSID    = 3'd3,
    MODE_FINISH   = 3'd4
  } mode_e;

  // one item for the back end: data byte, index, crc of the byte alone, last flag
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] crc1;
    logic       last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/scce_fifo.sv =====
// short item queue between front and back ends
`default_nettype none
module scce_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  scce_pkg::item_t      push_item_i,
  input  wire logic            pop_i,
  output scce_pkg::item_t      pop_item_o,
  output scce_pkg::q_stat_t    stat_o
);
  import scce_pkg::*;

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/scce_front.sv =====
// front end: accepts tagged bytes, keeps counters and crcs, queues items
`default_nettype none
module scce_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [2:0]      in_mode_i,
  input  wire logic [7:0]      in_byte_i,
  input  scce_pkg::q_stat_t    q_stat_i,
  output logic                 push_o,
  output scce_pkg::item_t      push_item_o
);
  import scce_pkg::*;

  typedef enum logic [1:0] {
    FE_DATA = 2'b01,
    FE_HDR  = 2'b10
  } fe_state_e;

  fe_state_e          state_q, state_d;
  logic [IpCntW-1:0]  ip_cnt_q;
  logic [PwCntW-1:0]  pw_cnt_q;
  logic [SsCntW-1:0]  ss_cnt_q;
  logic [BsCntW-1:0]  bs_cnt_q;
  logic [7:0]         ss_crc_q, bs_crc_q, xor_q;
  logic [7:0]         hdr_q [HdrItems];
  logic [HdrCntW-1:0] hdr_cnt_q;

  logic       accept;
  logic       hdr_last;
  logic       take_ip, take_pw, take_ss, take_bs, take_fin;
  logic [7:0] total, plen, hdr_xor;
  logic [7:0] push_data, push_idx;

  assign in_ready_o = (state_q == FE_DATA) && !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign hdr_last   = (hdr_cnt_q == HdrCntW'(HdrItems - 1));

  assign take_ip  = accept && (in_mode_i == MODE_IP)       && (ip_cnt_q < IpCntW'(IpLimit));
  assign take_pw  = accept && (in_mode_i == MODE_PASSWORD) &&
                    (pw_cnt_q < PwCntW'(PASSWORD_MAX));
  assign take_ss  = accept && (in_mode_i == MODE_SSID)     && (ss_cnt_q < SsCntW'(SSID_MAX));
  assign take_bs  = accept && (in_mode_i == MODE_BSSID)    &&
                    (bs_cnt_q < BsCntW'(BssidLimit));
  assign take_fin = accept && (in_mode_i == MODE_FINISH);

  assign total   = IdxBase + 8'(pw_cnt_q) + 8'(ss_cnt_q);
  assign plen    = 8'(pw_cnt_q);
  assign hdr_xor = xor_q ^ total ^ plen ^ ss_crc_q ^ bs_crc_q;

  always_comb begin
    push_o    = 1'b0;
    push_data = in_byte_i;
    push_idx  = '0;
    if (state_q == FE_HDR) begin
      push_o    = !q_stat_i.full;
      push_data = hdr_q[hdr_cnt_q];
      push_idx  = 8'(hdr_cnt_q);
    end else begin
      push_o = take_ip || take_pw || take_ss;
      if (take_ip) begin
        push_idx = IpIdxBase + 8'(ip_cnt_q);
      end else if (take_pw) begin
        push_idx = IdxBase + 8'(pw_cnt_q);
      end else begin
        push_idx = total;
      end
    end
  end

  assign push_item_o.data = push_data;
  assign push_item_o.idx  = push_idx;
  assign push_item_o.crc1 = crc8_update(8'h00, push_data);
  // data bytes always close their own triple; headers only on the last one
  assign push_item_o.last = (state_q == FE_HDR) ? hdr_last : 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_DATA: begin
        if (take_fin) state_d = FE_HDR;
      end
      FE_HDR: begin
        if (push_o && hdr_last) state_d = FE_DATA;
      end
      default: state_d = FE_DATA;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FE_DATA;
      ip_cnt_q  <= '0;
      pw_cnt_q  <= '0;
      ss_cnt_q  <= '0;
      bs_cnt_q  <= '0;
      ss_crc_q  <= '0;
      bs_crc_q  <= '0;
      xor_q     <= '0;
      hdr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (take_ip) begin
        ip_cnt_q <= ip_cnt_q + IpCntW'(1);
        xor_q    <= xor_q ^ in_byte_i;
      end
      if (take_pw) begin
        pw_cnt_q <= pw_cnt_q + PwCntW'(1);
        xor_q    <= xor_q ^ in_byte_i;
      end
      if (take_ss) begin
        ss_cnt_q <= ss_cnt_q + SsCntW'(1);
        ss_crc_q <= crc8_update(ss_crc_q, in_byte_i);
        xor_q    <= xor_q ^ in_byte_i;
      end
      if (take_bs) begin
        bs_cnt_q <= bs_cnt_q + BsCntW'(1);
        bs_crc_q <= crc8_update(bs_crc_q, in_byte_i);
      end
      if (take_fin) begin
        ip_cnt_q  <= '0;
        pw_cnt_q  <= '0;
        ss_cnt_q  <= '0;
        bs_cnt_q  <= '0;
        ss_crc_q  <= '0;
        bs_crc_q  <= '0;
        xor_q     <= '0;
        hdr_cnt_q <= '0;
      end
      if ((state_q == FE_HDR) && push_o) begin
        hdr_cnt_q <= hdr_last ? '0 : hdr_cnt_q + HdrCntW'(1);
      end
    end
  end

  // header snapshot taken at the finish request
  always_ff @(posedge clk_i) begin
    if (take_fin) begin
      hdr_q[0] <= total;
      hdr_q[1] <= plen;
      hdr_q[2] <= ss_crc_q;
      hdr_q[3] <= bs_crc_q;
      hdr_q[4] <= hdr_xor;
    end
  end

endmodule
`default_nettype wire

// ===== design/scce_back.sv =====
// back end: turns one queued item into three length codes
`default_nettype none
module scce_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  scce_pkg::q_stat_t    q_stat_i,
  input  scce_pkg::item_t      pop_item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [9:0]           out_code_o,
  output logic                 out_last_o
);
  import scce_pkg::*;

  typedef enum logic [2:0] {
    PH_HI  = 3'b001,
    PH_IDX = 3'b010,
    PH_LO  = 3'b100
  } phase_e;

  item_t      cur_q;
  logic       cur_valid_q;
  phase_e     phase_q;
  logic       out_valid_q, out_last_q;
  logic [9:0] out_code_q;

  logic       out_free, emit, done;
  logic [7:0] crc;
  logic [9:0] code;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = cur_valid_q && out_free;
  assign done     = emit && (phase_q == PH_LO);
  assign pop_o    = !q_stat_i.empty && (!cur_valid_q || done);
  assign crc      = crc8_update(cur_q.crc1, cur_q.idx);

  always_comb begin
    case (phase_q)
      PH_HI:   code = {2'b00, crc[7:4], cur_q.data[7:4]} + CodeOffset;
      PH_IDX:  code = {2'b01, cur_q.idx} + CodeOffset;
      PH_LO:   code = {2'b00, crc[3:0], cur_q.data[3:0]} + CodeOffset;
      default: code = CodeOffset;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      phase_q     <= PH_HI;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        cur_valid_q <= 1'b1;
        phase_q     <= PH_HI;
      end else if (done) begin
        cur_valid_q <= 1'b0;
        phase_q     <= PH_HI;
      end else if (emit) begin
        phase_q <= (phase_q == PH_HI) ? PH_IDX : PH_LO;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= pop_item_i;
    end
    if (emit) begin
      out_code_q <= code;
      out_last_q <= (phase_q == PH_LO) && cur_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

// ===== design/smart_config_length_code_encoder_unit.sv =====
// top level of the smart config length code encoder
// path: data bytes pass a queue entry and the current item register to the output register
// throughput: one code per cycle while an item waits and output is ready, so three codes
//   per ip, password or ssid byte, fifteen per finish, none for bssid or ignored bytes
// the four-entry queue lets the front take bytes while earlier codes are still going out
// reset: asynchronous, active low; clears counters, crcs, xor, queue and output valid
`default_nettype none
module smart_config_length_code_encoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // slave side request stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic [2:0]  s_axis_tuser_i,   // [2:0] mode
  // master side code stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [9:0] code, [15:10] zero
  output logic             m_axis_tlast_o    // is_last
);
  import scce_pkg::*;

  // items flowing from the classifier to the code generator
  item_t   push_item, pop_item;
  logic    push, pop;
  q_stat_t q_stat;
  logic [9:0] code;

  // front: classifies each request, updates counters, crcs and xor
  scce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_mode_i   (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // decoupling queue
  scce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  // back: second crc step and three codes per item through the output register
  scce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (code),
    .out_last_o  (m_axis_tlast_o)
  );

  // code padded to whole bytes
  assign m_axis_tdata_o = {6'b0, code};

endmodule
`default_nettype wire

// ===== design/scce_checker.sv =====
// port level checker for the smart config length code encoder, bound to the top level
`default_nettype none
module scce_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [2:0]  s_axis_tuser_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [15:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);
  import scce_pkg::*;

  // stalled code holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled code changed");

  // a finish request blocks new requests while headers are queued
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == MODE_FINISH) |=>
      !s_axis_tready_o)
    else $error("request taken during header sequence");

  // every code lies in the length code range
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tdata_o >= 16'd40) && (m_axis_tdata_o <= 16'd551))
    else $error("code out of range");

endmodule

bind smart_config_length_code_encoder_unit scce_checker u_scce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
`default_nettype wire

// ===== test/tb_smart_config_length_code_encoder_unit.sv =====
// self-checking testbench for the smart config length code encoder unit
`default_nettype none
module tb_smart_config_length_code_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import scce_pkg::*;

  // modes with no meaning, dropped by the block
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  localparam logic [7:0] CRC_POLY_REFLECTED = 8'h8c;
  localparam logic [9:0] CODE_BIAS          = 10'd40;
  localparam logic [7:0] IP_INDEX_BASE      = 8'd5;
  localparam logic [7:0] DATA_INDEX_BASE    = 8'd9;
  localparam int         HEADER_ITEMS       = 5;
  localparam int         IDLE_PCT           = 28;
  localparam int         STALL_LIMIT        = 2000;
  localparam int         SETTLE_CYCLES      = 20;
  localparam int         RANDOM_REQUESTS    = 10;
  localparam int         REPORT_LIMIT       = 10;

  typedef struct packed {
    logic [9:0] code;
    logic       last;
  } length_code_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [2:0]  s_tuser = MODE_IP;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  // codes still owed by the block, oldest first
  length_code_t pending_codes[$];

  // predicted block state
  int         ip_seen;
  int         password_seen;
  int         ssid_seen;
  int         bssid_seen;
  logic [7:0] ssid_crc_acc;
  logic [7:0] bssid_crc_acc;
  logic [7:0] xor_acc;

  int mismatches;
  int requests_sent;
  int codes_seen;
  int sessions_sent;
  int hold_request;
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;

  always #1 clk_i = ~clk_i;

  smart_config_length_code_encoder_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // [7:0] byte_value
    .s_axis_tuser_i  (s_tuser),   // [2:0] mode
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // [9:0] code, [15:10] zero
    .m_axis_tlast_o  (m_tlast)    // is_last
  );

  // crc-8/maxim, lsb first, one byte
  function automatic logic [7:0] maxim_step(input logic [7:0] seed, input logic [7:0] b);
    logic [7:0] r;
    r = seed ^ b;
    repeat (8) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFLECTED) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_state();
    ip_seen       = 0;
    password_seen = 0;
    ssid_seen     = 0;
    bssid_seen    = 0;
    ssid_crc_acc  = 8'h00;
    bssid_crc_acc = 8'h00;
    xor_acc       = 8'h00;
  endfunction

  // three codes per indexed byte: high nibbles, index, low nibbles
  function automatic void queue_item_codes(input logic [7:0] d, input logic [7:0] idx,
                                           input logic last);
    logic [7:0] c;
    c = maxim_step(maxim_step(8'h00, d), idx);
    pending_codes.push_back('{code: {2'b00, c[7:4], d[7:4]} + CODE_BIAS, last: 1'b0});
    pending_codes.push_back('{code: {2'b01, idx} + CODE_BIAS, last: 1'b0});
    pending_codes.push_back('{code: {2'b00, c[3:0], d[3:0]} + CODE_BIAS, last: last});
  endfunction

  function automatic void predict_codes(input logic [2:0] mode, input logic [7:0] value);
    logic [7:0] header[HEADER_ITEMS];
    case (mode)
      MODE_IP: begin
        if (ip_seen < IpLimit) begin
          queue_item_codes(value, IP_INDEX_BASE + 8'(ip_seen), 1'b1);
          ip_seen++;
          xor_acc ^= value;
        end
      end
      MODE_PASSWORD: begin
        if (password_seen < PASSWORD_MAX) begin
          queue_item_codes(value, DATA_INDEX_BASE + 8'(password_seen), 1'b1);
          password_seen++;
          xor_acc ^= value;
        end
      end
      MODE_SSID: begin
        // ssid index follows the password bytes seen so far
        if (ssid_seen < SSID_MAX) begin
          queue_item_codes(value, DATA_INDEX_BASE + 8'(password_seen + ssid_seen), 1'b1);
          ssid_seen++;
          ssid_crc_acc = maxim_step(ssid_crc_acc, value);
          xor_acc ^= value;
        end
      end
      MODE_BSSID: begin
        // only the crc and count move, nothing is emitted
        if (bssid_seen < BssidLimit) begin
          bssid_seen++;
          bssid_crc_acc = maxim_step(bssid_crc_acc, value);
        end
      end
      MODE_FINISH: begin
        header[0] = DATA_INDEX_BASE + 8'(password_seen + ssid_seen);
        header[1] = 8'(password_seen);
        header[2] = ssid_crc_acc;
        header[3] = bssid_crc_acc;
        header[4] = xor_acc ^ header[0] ^ header[1] ^ header[2] ^ header[3];
        for (int i = 0; i < HEADER_ITEMS; i++) begin
          queue_item_codes(header[i], 8'(i), i == HEADER_ITEMS - 1);
        end
        clear_state();
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_code(input logic [15:0] data, input logic last);
    length_code_t want;
    codes_seen++;
    if (pending_codes.size() == 0) begin
      note_mismatch($sformatf("unexpected code tdata %0d last %0b", data, last));
      return;
    end
    want = pending_codes.pop_front();
    if (data !== {6'd0, want.code}) begin
      note_mismatch($sformatf("code %0d: expected %0d, got tdata %0d",
                              codes_seen, want.code, data));
    end
    if (last !== want.last) begin
      note_mismatch($sformatf("code %0d: expected last %0b, got %0b",
                              codes_seen, want.last, last));
    end
  endfunction

  // byte values lean toward the extremes
  function automatic logic [7:0] any_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // offer one request, with random gaps before it, and predict on acceptance
  task automatic send_request(input logic [2:0] mode, input logic [7:0] value);
    while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    do @(posedge clk_i); while (!s_tready);
    predict_codes(mode, value);
    requests_sent++;
  endtask

  // sender goes quiet until every owed code has come out
  task automatic wait_for_codes();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_codes.size() != 0) @(posedge clk_i);
  endtask

  // one provisioning session, optionally shuffled and salted with unused modes
  task automatic send_session(input int n_ip, input int n_pw, input int n_ss, input int n_bs,
                              input bit mixed, input int noise_pct, input bit close);
    logic [2:0] kinds[$];
    logic [2:0] tmp;
    int         j;
    repeat (n_ip) kinds.push_back(MODE_IP);
    repeat (n_pw) kinds.push_back(MODE_PASSWORD);
    repeat (n_ss) kinds.push_back(MODE_SSID);
    repeat (n_bs) kinds.push_back(MODE_BSSID);
    if (mixed) begin
      for (int i = kinds.size() - 1; i > 0; i--) begin
        j        = $urandom_range(i);
        tmp      = kinds[i];
        kinds[i] = kinds[j];
        kinds[j] = tmp;
      end
    end
    foreach (kinds[i]) begin
      if ($urandom_range(99) < noise_pct) begin
        send_request(3'($urandom_range(MODE_UNUSED_LAST, MODE_UNUSED_FIRST)), any_byte());
      end
      send_request(kinds[i], any_byte());
    end
    if (close) begin
      send_request(MODE_FINISH, any_byte());
    end
    sessions_sent++;
  endtask

  // finish straight out of reset gives the header from zero state
  task automatic test_empty_finish();
    send_request(MODE_FINISH, 8'h00);
    wait_for_codes();
  endtask

  // field extremes, every mode, limits of ip and bssid, unused modes
  task automatic test_directed_fields();
    send_request(MODE_IP, 8'h00);
    send_request(MODE_IP, 8'hff);
    send_request(MODE_IP, 8'ha5);
    send_request(MODE_IP, 8'h5a);
    send_request(MODE_IP, 8'h3c);        // past the ip limit, dropped
    send_request(MODE_PASSWORD, 8'h00);
    send_request(MODE_PASSWORD, 8'hff);
    send_request(MODE_SSID, 8'hff);
    send_request(MODE_SSID, 8'h00);
    send_request(MODE_BSSID, 8'hff);
    send_request(MODE_BSSID, 8'h00);
    send_request(MODE_BSSID, 8'h81);
    send_request(MODE_BSSID, 8'h7e);
    send_request(MODE_BSSID, 8'h01);
    send_request(MODE_BSSID, 8'h80);
    send_request(MODE_BSSID, 8'h55);     // past the bssid limit, dropped
    for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++) begin
      send_request(3'(m), 8'hff);
    end
    send_request(MODE_FINISH, 8'hff);    // byte ignored on finish
    wait_for_codes();
  endtask

  // receiver holds off while the sender keeps offering, so the queue fills
  task automatic test_long_stall();
    tx_gaps      = 1'b0;
    hold_request = 150;
    send_session(1, 4, 2, 0, 1'b0, 0, 1'b1);
    wait_for_codes();
    tx_gaps = 1'b1;
  endtask

  // password and ssid counters driven past their limits, no idling on either side
  task automatic test_limit_session();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_session(0, PASSWORD_MAX + 1, SSID_MAX + 1, 0, 1'b0, 0, 1'b1);
    wait_for_codes();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // short sessions, some shuffled, some left open, some noise
  task automatic test_random_sessions();
    int stop_at;
    stop_at = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < stop_at) begin
      send_session($urandom_range(2), $urandom_range(3), $urandom_range(3),
                   $urandom_range(2), $urandom_range(3) == 0, 10,
                   $urandom_range(9) != 0);
      if ($urandom_range(3) == 0) begin
        wait_for_codes();
      end
    end
    send_request(MODE_FINISH, any_byte());
    wait_for_codes();
  endtask

  // result side: check each accepted code, then pick next ready
  initial begin
    int hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        check_code(m_tdata, m_tlast);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !rx_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // watchdog: too long with no request moving on either side
  initial begin
    int quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    clear_state();
    mismatches    = 0;
    requests_sent = 0;
    codes_seen    = 0;
    sessions_sent = 0;
    hold_request  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_finish();
    test_directed_fields();
    test_long_stall();
    test_limit_session();
    test_random_sessions();

    wait_for_codes();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d requests in %0d sessions, %0d codes checked",
             requests_sent, sessions_sent, codes_seen);
    $display("incl. limit overflow, unused modes, empty finish and a long output stall");
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
